/* hdl/rau_pkg.sv */
// Package for the rational arithmetic unit: mode codes and sequencer states.
// No dependencies.
`default_nettype none
package rau_pkg;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_CMP  = 3'd4;
    localparam logic [2:0] MODE_NORM = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMB,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* hdl/rational_arithmetic_unit.sv */
// Rational arithmetic unit top level: operand prep, shared multiplier,
// shared subtract/shift unit for gcd and division. Depends on rau_pkg.
`default_nettype none
// One transaction in, one out. Operands are sign/magnitude converted, the
// cross products are formed on one 32x32 multiplier in states ST_MUL1,
// ST_MUL2 and ST_MUL3, then a binary gcd and two restoring 64-bit divisions
// by the gcd follow; the divisions and the gcd's x > y subtract use one
// shared 64-bit subtractor. A reduced result comes after the gcd steps, the
// two divisions and a range check. Compare, zero results and division by
// zero go from the gcd state straight to done. Once the result is taken the
// unit returns to idle. in_stall is high whenever an operation is in flight.
module rational_arithmetic_unit #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] a_num,
    input  wire logic signed [31:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic [30:0]        b_den,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      res_num,
    output logic [30:0]             res_den,
    output logic                    less,
    output logic                    equal,
    output logic                    greater,
    output logic                    overflow
);

    localparam logic [63:0] LIM = 64'd1 << (VALUE_BITS - 1);

    rau_pkg::state_t state_reg, state_next;

    logic [2:0]  mode_reg;
    logic        an_reg, bn_reg;
    logic [31:0] am_reg, ad_reg, bm_reg, bd_reg;
    logic [63:0] t1_reg, t2_reg, dd_reg;
    logic        neg_reg;
    logic [63:0] x_reg, y_reg;
    logic [5:0]  sh_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] g_reg;
    logic [63:0] q_reg, r_reg;
    logic [63:0] mag_reg;

    logic [63:0] mul_a, mul_b, mul_p;
    logic [31:0] ma, mb;

    logic        in_fire;
    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != rau_pkg::ST_IDLE);

    // operand conversion
    logic        ann, adn;
    logic [31:0] anm, adm, bnm;
    logic        bnn;
    always_comb
    begin
        ann = a_num[31];
        anm = ann ? (32'd0 - a_num) : a_num;
        adn = a_den[31];
        adm = adn ? (32'd0 - a_den) : a_den;
        bnn = b_num[31];
        bnm = bnn ? (32'd0 - b_num) : b_num;
    end

    always_comb
    begin
        ma = am_reg;
        mb = bd_reg;
        unique case (state_reg)
            rau_pkg::ST_MUL1:
            begin
                ma = am_reg;
                mb = (mode_reg == rau_pkg::MODE_MUL) ? bm_reg : bd_reg;
            end
            rau_pkg::ST_MUL2:
            begin
                ma = bm_reg;
                mb = ad_reg;
                if (mode_reg == rau_pkg::MODE_MUL)
                begin
                    ma = ad_reg;
                    mb = bd_reg;
                end
            end
            rau_pkg::ST_MUL3:
            begin
                ma = ad_reg;
                mb = (mode_reg == rau_pkg::MODE_DIV) ? bm_reg : bd_reg;
            end
            default:
            begin
                ma = am_reg;
                mb = bd_reg;
            end
        endcase
        mul_a = {32'd0, ma};
        mul_b = {32'd0, mb};
        mul_p = mul_a[31:0] * mul_b[31:0];
    end

    // shared subtractor
    logic [63:0] sub_a, sub_b, sub_d;
    logic [63:0] rsh;
    logic        div_bit;
    always_comb
    begin
        rsh = {r_reg[62:0], q_reg[63]};
        sub_a = x_reg;
        sub_b = y_reg;
        if (state_reg == rau_pkg::ST_DIV_NUM || state_reg == rau_pkg::ST_DIV_DEN)
        begin
            sub_a = rsh;
            sub_b = g_reg;
        end
        sub_d = sub_a - sub_b;
        div_bit = !sub_d[63] || r_reg[63];
    end

    logic        s1, s2;
    logic [63:0] comb_mag;
    logic        comb_neg;
    always_comb
    begin
        s1 = an_reg && (t1_reg != 64'd0);
        s2 = (mode_reg == rau_pkg::MODE_SUB) ? (!bn_reg && (t2_reg != 64'd0))
                                             : (bn_reg && (t2_reg != 64'd0));
        if (s1 == s2)
        begin
            comb_mag = t1_reg + t2_reg;
            comb_neg = s1;
        end
        else if (t1_reg >= t2_reg)
        begin
            comb_mag = t1_reg - t2_reg;
            comb_neg = s1;
        end
        else
        begin
            comb_mag = t2_reg - t1_reg;
            comb_neg = s2;
        end
    end

    logic signed [64:0] cx, cy;
    always_comb
    begin
        cx = an_reg ? -$signed({1'b0, t1_reg}) : $signed({1'b0, t1_reg});
        cy = bn_reg ? -$signed({1'b0, t2_reg}) : $signed({1'b0, t2_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE:
                if (in_fire)
                    state_next = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1:
                state_next = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:
                state_next = rau_pkg::ST_MUL3;
            rau_pkg::ST_MUL3:
                state_next = rau_pkg::ST_COMB;
            rau_pkg::ST_COMB:
                state_next = rau_pkg::ST_GCD;
            rau_pkg::ST_GCD:
                if (x_reg == 64'd0 || y_reg == 64'd0)
                    state_next = rau_pkg::ST_DONE;
                else if (x_reg == y_reg)
                    state_next = rau_pkg::ST_DIV_NUM;
            rau_pkg::ST_DIV_NUM:
                if (cnt_reg == 6'd63)
                    state_next = rau_pkg::ST_DIV_DEN;
            rau_pkg::ST_DIV_DEN:
                if (cnt_reg == 6'd63)
                    state_next = rau_pkg::ST_CHECK;
            rau_pkg::ST_CHECK:
                state_next = rau_pkg::ST_DONE;
            rau_pkg::ST_DONE:
                if (!out_stall)
                    state_next = rau_pkg::ST_IDLE;
            default:
                state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rau_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (state_next == rau_pkg::ST_DONE && state_reg != rau_pkg::ST_DONE)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            rau_pkg::ST_IDLE:
                if (in_fire)
                begin
                    mode_reg <= mode;
                    if (anm == 32'd0 || adm == 32'd0)
                    begin
                        an_reg <= 1'b0;
                        am_reg <= 32'd0;
                        ad_reg <= 32'd1;
                    end
                    else
                    begin
                        an_reg <= ann ^ adn;
                        am_reg <= anm;
                        ad_reg <= adm;
                    end
                    if (bnm == 32'd0 || b_den == 31'd0)
                    begin
                        bn_reg <= 1'b0;
                        bm_reg <= 32'd0;
                        bd_reg <= 32'd1;
                    end
                    else
                    begin
                        bn_reg <= bnn;
                        bm_reg <= bnm;
                        bd_reg <= {1'b0, b_den};
                    end
                    res_num  <= '0;
                    res_den  <= '0;
                    less     <= 1'b0;
                    equal    <= 1'b0;
                    greater  <= 1'b0;
                    overflow <= 1'b0;
                end
            rau_pkg::ST_MUL1:
                t1_reg <= mul_p;
            rau_pkg::ST_MUL2:
                t2_reg <= mul_p;
            rau_pkg::ST_MUL3:
                dd_reg <= mul_p;
            rau_pkg::ST_COMB:
            begin
                sh_reg  <= 6'd0;
                cnt_reg <= 6'd0;
                unique case (mode_reg) inside
                    rau_pkg::MODE_ADD, rau_pkg::MODE_SUB:
                    begin
                        neg_reg <= comb_neg && (comb_mag != 64'd0);
                        mag_reg <= comb_mag;
                        x_reg   <= comb_mag;
                        y_reg   <= dd_reg;
                    end
                    rau_pkg::MODE_MUL:
                    begin
                        neg_reg <= an_reg != bn_reg;
                        mag_reg <= t1_reg;
                        x_reg   <= t1_reg;
                        y_reg   <= t2_reg;
                        dd_reg  <= t2_reg;
                    end
                    rau_pkg::MODE_DIV:
                    begin
                        neg_reg <= an_reg != bn_reg;
                        mag_reg <= t1_reg;
                        x_reg   <= (bm_reg != 32'd0) ? t1_reg : 64'd0;
                        y_reg   <= dd_reg;
                    end
                    rau_pkg::MODE_CMP:
                    begin
                        less    <= cx < cy;
                        equal   <= cx == cy;
                        greater <= cx > cy;
                        x_reg   <= 64'd0;
                        y_reg   <= 64'd0;
                    end
                    rau_pkg::MODE_NORM:
                    begin
                        neg_reg <= an_reg;
                        mag_reg <= {32'd0, am_reg};
                        x_reg   <= {32'd0, am_reg};
                        y_reg   <= {32'd0, ad_reg};
                        dd_reg  <= {32'd0, ad_reg};
                    end
                    default:
                    begin
                        x_reg <= 64'd0;
                        y_reg <= 64'd0;
                    end
                endcase
            end
            rau_pkg::ST_GCD:
            begin
                // binary gcd: strip common twos, then subtract
                if (x_reg != 64'd0 && y_reg != 64'd0)
                begin
                    if (x_reg == y_reg)
                    begin
                        g_reg   <= x_reg << sh_reg;
                        q_reg   <= mag_reg;
                        r_reg   <= 64'd0;
                        cnt_reg <= 6'd0;
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg  <= x_reg >> 1;
                        y_reg  <= y_reg >> 1;
                        sh_reg <= sh_reg + 6'd1;
                    end
                    else if (!x_reg[0])
                        x_reg <= x_reg >> 1;
                    else if (!y_reg[0])
                        y_reg <= y_reg >> 1;
                    else if (x_reg > y_reg)
                        x_reg <= sub_d >> 1;
                    else
                        y_reg <= (y_reg - x_reg) >> 1;
                end
            end
            rau_pkg::ST_DIV_NUM, rau_pkg::ST_DIV_DEN:
            begin
                if (cnt_reg == 6'd63)
                begin
                    cnt_reg <= 6'd0;
                    r_reg   <= 64'd0;
                    if (state_reg == rau_pkg::ST_DIV_NUM)
                    begin
                        mag_reg <= {q_reg[62:0], div_bit};
                        q_reg   <= dd_reg;
                    end
                    else
                        dd_reg <= {q_reg[62:0], div_bit};
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    r_reg   <= div_bit ? sub_d : rsh;
                    q_reg   <= {q_reg[62:0], div_bit};
                end
            end
            rau_pkg::ST_CHECK:
            begin
                if (dd_reg > LIM - 64'd1 || mag_reg > (neg_reg ? LIM : LIM - 64'd1))
                    overflow <= 1'b1;
                else
                begin
                    res_num <= neg_reg ? (32'd0 - mag_reg[31:0]) : mag_reg[31:0];
                    res_den <= dd_reg[30:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == rau_pkg::MODE_CMP) |-> $onehot({less, equal, greater}))
        else $error("compare flags not one-hot");
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (res_num == 32'sd0 && res_den == 31'd0))
        else $error("overflow with nonzero result");

endmodule
`default_nettype wire
